>>> hw/rtl/pidpmc_pkg.sv
// constants and register indexes for the position pid controller
package pidpmc_pkg;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int POS_W   = 16;
   localparam int ERR_W   = 17;
   localparam int DIFF_W  = 18;
   localparam int INTEG_W = 32;
   localparam int ACC_W   = 64;
   localparam int MUL_W   = 32;
   localparam int Q_SHIFT = 24;

   localparam int DIV_STEPS = 49;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   localparam logic [CSR_ADDR_W-1:0] CSR_PROP_GAIN  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_INTEG_GAIN = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_DERIV_GAIN = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_DEADBAND   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_DRIVE  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_DRIVE  = 3'd5;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   localparam logic [14:0] PROP_GAIN_RST  = 15'd1;
   localparam logic [31:0] INTEG_GAIN_RST = 32'd1678;
   localparam logic [31:0] DERIV_GAIN_RST = 32'd838861;
   localparam logic [15:0] DEADBAND_RST   = 16'd10;
   localparam logic [15:0] MAX_DRIVE_RST  = 16'd3000;
   localparam logic [15:0] MIN_DRIVE_RST  = 16'd0;

   localparam logic [ACC_W-1:0] TERM_LIMIT = 64'h1000_0000_0000_0000;
   localparam logic [31:0]      POS_LIMIT  = 32'h7FFF_FFFF;
   localparam logic [31:0]      NEG_LIMIT  = 32'h8000_0000;

endpackage

>>> hw/rtl/pid_position_motor_control_top.sv
// encoder position pid controller with one shared multiplier and a serial divider
// start words and steps inside the deadband give their result in the cycle after acceptance
// an active step runs the 32x32 multiplier passes and, when elapsed_ms is nonzero,
// the one-bit-per-cycle derivative divider
// a new word is taken once the previous result is out of the output register
// synchronous active-high reset loads default gains and clears the loop state
module pid_position_motor_control_top import pidpmc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // target_count, position, elapsed_ms
   input  logic                  req_tuser,   // cmd
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // direction, drive, settled, zero pad
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL_AREA, ST_AREA, ST_MUL_P, ST_PTERM, ST_MUL_I, ST_ITERM,
      ST_MUL_D, ST_DIV, ST_DTERM, ST_ABS, ST_OUT
   } state_type;

   state_type state_ff;

   logic [14:0] prop_ff;
   logic [31:0] igain_ff, dgain_ff;
   logic [15:0] deadband_ff, max_ff, min_ff;

   logic [POS_W-1:0]   target_ff;
   logic [ERR_W-1:0]   err_ff, prev_ff;
   logic [INTEG_W-1:0] integ_ff;
   logic [15:0]        dt_ff;
   logic [ACC_W-1:0]   prod_ff, acc_ff;
   logic [15:0]        rem_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               dsign_ff, neg_ff;

   logic               rsp_valid_ff, dir_ff, settled_ff;
   logic [15:0]        drive_ff;

   logic [POS_W-1:0]   req_target, req_pos;
   logic [15:0]        req_dt;
   logic               accept;
   logic               rsp_load;

   logic [ERR_W-1:0]   err_new, err_new_mag, err_mag;
   logic [DIFF_W-1:0]  diff, diff_mag;
   logic [INTEG_W-1:0] integ_mag;
   logic [MUL_W-1:0]   mul_a, mul_b;
   logic [ACC_W-1:0]   prod_in;

   logic [34:0]        area_term, area_sum;
   logic [INTEG_W-1:0] integ_in;
   logic [ACC_W-1:0]   pmag, imag, term_in;

   logic [ERR_W-1:0]   rem_sh;
   logic               rem_ge;
   logic [15:0]        rem_in;

   logic [39:0]        whole_mag;
   logic [31:0]        sat_lim, sat_mag;
   logic [30:0]        half, clamp_hi, clamp_lo;
   logic               out_free;

   assign req_target = req_tdata[15:0];
   assign req_pos    = req_tdata[31:16];
   assign req_dt     = req_tdata[47:32];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;

   // result register loads on quick answers at acceptance and at the end of an active step
   assign rsp_load   = (accept && ((req_tuser == CMD_START) || (err_mag <= {1'b0, deadband_ff})))
                       || ((state_ff == ST_OUT) && out_free);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, settled_ff, drive_ff, dir_ff};

   always_comb begin
      if (req_tuser == CMD_START) begin
         err_new = {req_target[POS_W-1], req_target} - {req_pos[POS_W-1], req_pos};
      end else begin
         err_new = {target_ff[POS_W-1], target_ff} - {req_pos[POS_W-1], req_pos};
      end
      err_new_mag = err_new[ERR_W-1] ? (~err_new + 1'b1) : err_new;
      err_mag     = err_ff[ERR_W-1] ? (~err_ff + 1'b1) : err_ff;
      integ_mag   = integ_ff[INTEG_W-1] ? (~integ_ff + 1'b1) : integ_ff;
      diff        = {err_ff[ERR_W-1], err_ff} - {prev_ff[ERR_W-1], prev_ff};
      diff_mag    = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
   end

   // shared multiplier operand select
   always_comb begin
      unique case (state_ff)
         ST_MUL_AREA: begin
            mul_a = {15'd0, err_mag};
            mul_b = {16'd0, dt_ff};
         end
         ST_MUL_P: begin
            mul_a = {15'd0, err_mag};
            mul_b = {17'd0, prop_ff};
         end
         ST_MUL_I: begin
            mul_a = integ_mag;
            mul_b = igain_ff;
         end
         ST_MUL_D: begin
            mul_a = {14'd0, diff_mag};
            mul_b = dgain_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = {32'd0, mul_a} * {32'd0, mul_b};
   end

   always_comb begin
      area_term = err_ff[ERR_W-1] ? (35'd0 - {3'd0, prod_ff[31:0]}) : {3'd0, prod_ff[31:0]};
      area_sum  = {{3{integ_ff[INTEG_W-1]}}, integ_ff} + area_term;
      if (area_sum[34:31] == 4'b0000 || area_sum[34:31] == 4'b1111) begin
         integ_in = area_sum[31:0];
      end else if (area_sum[34]) begin
         integ_in = NEG_LIMIT;
      end else begin
         integ_in = POS_LIMIT;
      end

      pmag = {prod_ff[ACC_W-Q_SHIFT-1:0], {Q_SHIFT{1'b0}}};
      imag = (prod_ff > TERM_LIMIT) ? TERM_LIMIT : prod_ff;
      case (state_ff)
         ST_PTERM: term_in = err_ff[ERR_W-1] ? (64'd0 - pmag) : pmag;
         ST_ITERM: term_in = integ_ff[INTEG_W-1] ? (64'd0 - imag) : imag;
         default:  term_in = dsign_ff ? (64'd0 - prod_ff) : prod_ff;
      endcase
   end

   // restoring divide step, dividend shifts through prod_ff
   always_comb begin
      rem_sh = {rem_ff, prod_ff[DIV_STEPS-1]};
      rem_ge = rem_sh >= {1'b0, dt_ff};
      if (rem_ge) begin
         rem_in = 16'(rem_sh - {1'b0, dt_ff});
      end else begin
         rem_in = rem_sh[15:0];
      end
   end

   always_comb begin
      whole_mag = acc_ff[ACC_W-1:Q_SHIFT];
      sat_lim   = neg_ff ? NEG_LIMIT : POS_LIMIT;
      sat_mag   = (whole_mag > {8'd0, sat_lim}) ? sat_lim : whole_mag[31:0];
      half      = sat_mag[31:1];
      clamp_hi  = (half > {15'd0, max_ff}) ? {15'd0, max_ff} : half;
      clamp_lo  = (clamp_hi < {15'd0, min_ff}) ? {15'd0, min_ff} : clamp_hi;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prop_ff      <= PROP_GAIN_RST;
         igain_ff     <= INTEG_GAIN_RST;
         dgain_ff     <= DERIV_GAIN_RST;
         deadband_ff  <= DEADBAND_RST;
         max_ff       <= MAX_DRIVE_RST;
         min_ff       <= MIN_DRIVE_RST;
         target_ff    <= '0;
         err_ff       <= '0;
         prev_ff      <= '0;
         integ_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               CSR_PROP_GAIN:  prop_ff     <= csr_wdata[14:0];
               CSR_INTEG_GAIN: igain_ff    <= csr_wdata;
               CSR_DERIV_GAIN: dgain_ff    <= csr_wdata;
               CSR_DEADBAND:   deadband_ff <= csr_wdata[15:0];
               CSR_MAX_DRIVE:  max_ff      <= csr_wdata[15:0];
               CSR_MIN_DRIVE:  min_ff      <= csr_wdata[15:0];
               default: ;
            endcase
         end

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_tuser == CMD_START) begin
                     target_ff    <= req_target;
                     err_ff       <= err_new;
                     integ_ff     <= '0;
                     prev_ff      <= '0;
                     dir_ff       <= 1'b0;
                     drive_ff     <= '0;
                     settled_ff   <= err_new_mag <= {1'b0, deadband_ff};
                  end else if (err_mag <= {1'b0, deadband_ff}) begin
                     dir_ff       <= 1'b0;
                     drive_ff     <= '0;
                     settled_ff   <= 1'b1;
                  end else begin
                     err_ff   <= err_new;
                     dt_ff    <= req_dt;
                     state_ff <= ST_MUL_AREA;
                  end
               end
            end
            ST_MUL_AREA: begin
               prod_ff  <= prod_in;
               state_ff <= ST_AREA;
            end
            ST_AREA: begin
               integ_ff <= integ_in;
               state_ff <= ST_MUL_P;
            end
            ST_MUL_P: begin
               prod_ff  <= prod_in;
               state_ff <= ST_PTERM;
            end
            ST_PTERM: begin
               acc_ff   <= term_in;
               state_ff <= ST_MUL_I;
            end
            ST_MUL_I: begin
               prod_ff  <= prod_in;
               state_ff <= ST_ITERM;
            end
            ST_ITERM: begin
               acc_ff   <= acc_ff + term_in;
               state_ff <= ST_MUL_D;
            end
            ST_MUL_D: begin
               prod_ff  <= prod_in;
               dsign_ff <= diff[DIFF_W-1];
               prev_ff  <= err_ff;
               rem_ff   <= '0;
               cnt_ff   <= '0;
               state_ff <= (dt_ff == 16'd0) ? ST_ABS : ST_DIV;
            end
            ST_DIV: begin
               rem_ff                 <= rem_in;
               prod_ff[DIV_STEPS-1:0] <= {prod_ff[DIV_STEPS-2:0], rem_ge};
               cnt_ff                 <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
                  state_ff <= ST_DTERM;
               end
            end
            ST_DTERM: begin
               acc_ff   <= acc_ff + term_in;
               state_ff <= ST_ABS;
            end
            ST_ABS: begin
               neg_ff   <= acc_ff[ACC_W-1];
               acc_ff   <= acc_ff[ACC_W-1] ? (64'd0 - acc_ff) : acc_ff;
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (out_free) begin
                  dir_ff       <= err_ff[ERR_W-1] || (err_ff == '0);
                  drive_ff     <= clamp_lo[15:0];
                  settled_ff   <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

>>> dv/tb_pid_position_motor_control_top.sv
// self-checking testbench for the position pid controller: directed table, then random moves
`timescale 1ns / 1ps

module tb_pid_position_motor_control_top;
   import pidpmc_pkg::*;

   typedef struct packed {
      logic        settled;
      logic [15:0] drive;
      logic        dir;
   } motor_out_type;

   typedef struct packed {
      logic          fixed;
      motor_out_type ans;
   } typed_answer_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [CSR_ADDR_W-1:0] addr;
      logic [31:0]           wdata;
      logic                  cmd;
      int                    tgt;
      int                    pos;
      int                    el;
      bit                    fixed;
      logic                  dir;
      int                    drv;
      logic                  stl;
   } row_type;

   localparam int PLAN_LEN    = 33;
   localparam int PHASES      = 8;
   localparam int PHASE_WORDS = 230;

   row_type plan [PLAN_LEN] = '{
      '{ROW_ITEM, CSR_PROP_GAIN,  0,            CMD_STEP,  0,      1234,   5,     1, 0, 0,     1},
      '{ROW_ITEM, CSR_PROP_GAIN,  0,            CMD_START, 32767,  -32768, 0,     1, 0, 0,     0},
      '{ROW_ITEM, CSR_PROP_GAIN,  0,            CMD_STEP,  0,      -32768, 0,     0, 0, 0,     0},
      '{ROW_ITEM, CSR_PROP_GAIN,  0,            CMD_STEP,  0,      0,      65535, 0, 0, 0,     0},
      '{ROW_ITEM, CSR_PROP_GAIN,  0,            CMD_STEP,  0,      32767,  65535, 0, 0, 0,     0},
      '{ROW_ITEM, CSR_PROP_GAIN,  0,            CMD_STEP,  0,      0,      1,     1, 0, 0,     1},
      '{ROW_ITEM, CSR_PROP_GAIN,  0,            CMD_START, -32768, 32767,  0,     1, 0, 0,     0},
      '{ROW_ITEM, CSR_PROP_GAIN,  0,            CMD_STEP,  0,      32767,  1,     0, 0, 0,     0},
      '{ROW_CSR,  CSR_PROP_GAIN,  32767,        CMD_START, 0,      0,      0,     0, 0, 0,     0},
      '{ROW_CSR,  CSR_INTEG_GAIN, 32'hFFFFFFFF, CMD_START, 0,      0,      0,     0, 0, 0,     0},
      '{ROW_CSR,  CSR_DERIV_GAIN, 32'hFFFFFFFF, CMD_START, 0,      0,      0,     0, 0, 0,     0},
      '{ROW_CSR,  CSR_MAX_DRIVE,  65535,        CMD_START, 0,      0,      0,     0, 0, 0,     0},
      '{ROW_ITEM, CSR_PROP_GAIN,  0,            CMD_START, -32768, 32767,  0,     1, 0, 0,     0},
      '{ROW_ITEM, CSR_PROP_GAIN,  0,            CMD_STEP,  0,      32767,  65535, 1, 1, 65535, 0},
      '{ROW_CSR,  CSR_MIN_DRIVE,  100,          CMD_START, 0,      0,      0,     0, 0, 0,     0},
      '{ROW_CSR,  CSR_MAX_DRIVE,  5,            CMD_START, 0,      0,      0,     0, 0, 0,     0},
      '{ROW_CSR,  CSR_PROP_GAIN,  0,            CMD_START, 0,      0,      0,     0, 0, 0,     0},
      '{ROW_CSR,  CSR_INTEG_GAIN, 0,            CMD_START, 0,      0,      0,     0, 0, 0,     0},
      '{ROW_CSR,  CSR_DERIV_GAIN, 0,            CMD_START, 0,      0,      0,     0, 0, 0,     0},
      '{ROW_ITEM, CSR_PROP_GAIN,  0,            CMD_STEP,  0,      32767,  3,     1, 1, 100,   0},
      '{ROW_CSR,  CSR_DEADBAND,   65535,        CMD_START, 0,      0,      0,     0, 0, 0,     0},
      '{ROW_ITEM, CSR_PROP_GAIN,  0,            CMD_START, 32767,  -32768, 0,     1, 0, 0,     1},
      '{ROW_ITEM, CSR_PROP_GAIN,  0,            CMD_STEP,  0,      5,      7,     1, 0, 0,     1},
      '{ROW_CSR,  CSR_DEADBAND,   0,            CMD_START, 0,      0,      0,     0, 0, 0,     0},
      '{ROW_CSR,  CSR_MIN_DRIVE,  0,            CMD_START, 0,      0,      0,     0, 0, 0,     0},
      '{ROW_CSR,  CSR_MAX_DRIVE,  3000,         CMD_START, 0,      0,      0,     0, 0, 0,     0},
      '{ROW_CSR,  CSR_PROP_GAIN,  1,            CMD_START, 0,      0,      0,     0, 0, 0,     0},
      '{ROW_CSR,  CSR_INTEG_GAIN, 1678,         CMD_START, 0,      0,      0,     0, 0, 0,     0},
      '{ROW_CSR,  CSR_DERIV_GAIN, 838861,       CMD_START, 0,      0,      0,     0, 0, 0,     0},
      '{ROW_ITEM, CSR_PROP_GAIN,  0,            CMD_START, 0,      0,      0,     1, 0, 0,     1},
      '{ROW_ITEM, CSR_PROP_GAIN,  0,            CMD_START, 1,      0,      0,     1, 0, 0,     0},
      '{ROW_ITEM, CSR_PROP_GAIN,  0,            CMD_STEP,  0,      0,      2,     0, 0, 0,     0},
      '{ROW_ITEM, CSR_PROP_GAIN,  0,            CMD_STEP,  0,      1,      0,     0, 0, 0,     0}
   };

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // target_count, position, elapsed_ms
   logic                  req_tuser  = 1'b0; // cmd
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // direction, drive, settled, zero pad
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   pid_position_motor_control_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // controller copy: gains, limits and loop state
   longint kp, ki, kd, dband, dmax, dmin;
   longint tgt_hold, err_hold, integ_acc, prev_err;

   motor_out_type    drive_answers_q [$];
   typed_answer_type typed_answers_q [$];
   int               words_sent   = 0;
   int               answers_seen = 0;
   int               fail_count   = 0;
   bit               tx_idle_on   = 1'b1;
   bit               rx_idle_on   = 1'b1;
   motor_out_type    guess, want, got;
   typed_answer_type typed;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic longint magnitude(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic int clamp16(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic motor_out_type pid_predict(logic cmd, logic signed [15:0] tgt,
                                                 logic signed [15:0] pos, logic [15:0] el);
      motor_out_type r;
      longint e, dt, pterm, iterm, dterm, whole, mag;
      r  = '0;
      dt = longint'(el);
      if (cmd == CMD_START) begin
         tgt_hold  = longint'(tgt);
         err_hold  = longint'(tgt) - longint'(pos);
         integ_acc = 0;
         prev_err  = 0;
         r.settled = (magnitude(err_hold) <= dband);
         return r;
      end
      if (magnitude(err_hold) <= dband) begin
         r.settled = 1'b1;
         return r;
      end
      e         = tgt_hold - longint'(pos);
      err_hold  = e;
      r.dir     = (e > 0) ? 1'b0 : 1'b1;
      integ_acc = sat32(integ_acc + e * dt);
      pterm     = e * kp * (64'sd1 <<< Q_SHIFT);
      mag       = magnitude(integ_acc) * ki;
      if (mag > longint'(TERM_LIMIT)) mag = longint'(TERM_LIMIT);
      iterm     = (integ_acc < 0) ? -mag : mag;
      dterm     = (dt != 0) ? ((e - prev_err) * kd) / dt : 0;
      prev_err  = e;
      whole     = sat32((pterm + iterm + dterm) / (64'sd1 <<< Q_SHIFT));
      mag       = magnitude(whole) / 2;
      if (mag > dmax) mag = dmax;
      if (mag < dmin) mag = dmin;
      r.drive   = mag[15:0];
      return r;
   endfunction

   task automatic report_mismatch(string what);
      fail_count++;
      $display("%0t ERROR: %s", $time, what);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         kp        = 1;
         ki        = 1678;
         kd        = 838861;
         dband     = 10;
         dmax      = 3000;
         dmin      = 0;
         tgt_hold  = 0;
         err_hold  = 0;
         integ_acc = 0;
         prev_err  = 0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_PROP_GAIN:  kp    = longint'(csr_wdata[14:0]);
               CSR_INTEG_GAIN: ki    = longint'(csr_wdata);
               CSR_DERIV_GAIN: kd    = longint'(csr_wdata);
               CSR_DEADBAND:   dband = longint'(csr_wdata[15:0]);
               CSR_MAX_DRIVE:  dmax  = longint'(csr_wdata[15:0]);
               CSR_MIN_DRIVE:  dmin  = longint'(csr_wdata[15:0]);
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            guess = pid_predict(req_tuser, req_tdata[15:0], req_tdata[31:16],
                                req_tdata[47:32]);
            typed = '0;
            if (typed_answers_q.size() > 0) typed = typed_answers_q.pop_front();
            drive_answers_q.push_back(typed.fixed ? typed.ans : guess);
         end
         if (rsp_tvalid && rsp_tready) begin
            answers_seen++;
            got = motor_out_type'(rsp_tdata[17:0]);
            if (drive_answers_q.size() == 0) begin
               report_mismatch($sformatf("result word with nothing expected: %h", rsp_tdata));
            end else begin
               want = drive_answers_q.pop_front();
               if (got.dir !== want.dir)
                  report_mismatch($sformatf("direction got %0d want %0d", got.dir, want.dir));
               if (got.drive !== want.drive)
                  report_mismatch($sformatf("drive got %0d want %0d", got.drive, want.drive));
               if (got.settled !== want.settled)
                  report_mismatch($sformatf("settled got %0d want %0d",
                                            got.settled, want.settled));
            end
         end
      end
   end

   // result side back-pressure
   initial begin
      wait (!reset);
      @(posedge clock);
      forever begin
         if (rx_idle_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   task automatic send_word(logic cmd, logic [15:0] tgt, logic [15:0] pos, logic [15:0] el,
                            bit fixed, motor_out_type ans);
      if (tx_idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      typed_answers_q.push_back('{fixed: fixed, ans: ans});
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {el, pos, tgt};
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (answers_seen != words_sent) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_put(logic [CSR_ADDR_W-1:0] addr, logic [31:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   initial begin
      bit          in_csr;
      int          n, tgt, pos, el, steps;
      logic [31:0] cfg_kp, cfg_ki, cfg_kd, cfg_db, cfg_max, cfg_min;
      in_csr = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            if (!in_csr) drain();
            in_csr = 1'b1;
            csr_put(plan[i].addr, plan[i].wdata);
         end else begin
            if (in_csr) csr_we <= 1'b0;
            in_csr = 1'b0;
            send_word(plan[i].cmd, 16'(plan[i].tgt), 16'(plan[i].pos), 16'(plan[i].el),
                      plan[i].fixed, '{settled: plan[i].stl, drive: 16'(plan[i].drv),
                                      dir: plan[i].dir});
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         case ($urandom_range(0, 5))
            0:       cfg_kp = 0;
            1:       cfg_kp = 32767;
            2:       cfg_kp = $urandom;
            default: cfg_kp = $urandom_range(1, 64);
         endcase
         case ($urandom_range(0, 4))
            0:       cfg_ki = 0;
            1:       cfg_ki = 32'hFFFFFFFF;
            2:       cfg_ki = $urandom;
            default: cfg_ki = $urandom_range(0, 1 << 22);
         endcase
         case ($urandom_range(0, 4))
            0:       cfg_kd = 0;
            1:       cfg_kd = 32'hFFFFFFFF;
            2:       cfg_kd = $urandom;
            default: cfg_kd = $urandom_range(0, 1 << 24);
         endcase
         case ($urandom_range(0, 11))
            0:       cfg_db = 65535;
            1:       cfg_db = 0;
            default: cfg_db = $urandom_range(0, 60);
         endcase
         case ($urandom_range(0, 5))
            0:       cfg_max = 65535;
            1:       cfg_max = 0;
            default: cfg_max = $urandom_range(100, 65535);
         endcase
         case ($urandom_range(0, 3))
            0:       cfg_min = $urandom_range(0, 65535);
            1:       cfg_min = $urandom_range(0, 200);
            default: cfg_min = 0;
         endcase
         csr_put(CSR_PROP_GAIN, cfg_kp);
         csr_put(CSR_INTEG_GAIN, cfg_ki);
         csr_put(CSR_DERIV_GAIN, cfg_kd);
         csr_put(CSR_DEADBAND, cfg_db);
         csr_put(CSR_MAX_DRIVE, cfg_max);
         csr_put(CSR_MIN_DRIVE, cfg_min);
         csr_we <= 1'b0;
         tx_idle_on = (ph != 3 && ph != PHASES - 1);
         rx_idle_on = tx_idle_on;

         n = 0;
         while (n < PHASE_WORDS) begin
            if ($urandom_range(0, 9) == 0) begin
               send_word(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                         16'($urandom), 1'b0, '0);
               n++;
            end else begin
               if ($urandom_range(0, 39) == 0) drain();
               tgt = $urandom_range(0, 65535) - 32768;
               if ($urandom_range(0, 3) == 0)
                  pos = $urandom_range(0, 65535) - 32768;
               else
                  pos = clamp16(tgt + $urandom_range(0, 4000) - 2000);
               send_word(CMD_START, 16'(tgt), 16'(pos), 16'($urandom_range(0, 50)), 1'b0, '0);
               n++;
               steps = $urandom_range(1, 30);
               repeat (steps) begin
                  pos = clamp16(pos + (tgt - pos) / int'($urandom_range(1, 4))
                                + $urandom_range(0, 20) - 10);
                  case ($urandom_range(0, 19))
                     0:       el = 0;
                     1:       el = $urandom_range(0, 65535);
                     default: el = $urandom_range(1, 25);
                  endcase
                  send_word(CMD_STEP, 16'($urandom), 16'(pos), 16'(el), 1'b0, '0);
                  n++;
               end
            end
         end
      end

      drain();
      repeat (70) @(posedge clock);
      if (drive_answers_q.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", drive_answers_q.size()));
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/pidpmc_pkg.sv
hw/rtl/pid_position_motor_control_top.sv
dv/tb_pid_position_motor_control_top.sv
